>>> hw/rtl/xtea_pkg.sv
`default_nettype none

package xtea_pkg;

    localparam int ROUND_COUNT_DEFAULT = 32;
    localparam logic [31:0] DELTA = 32'h9E37_79B9;
    localparam int KEY_WORDS = 4;
    localparam int WORD_W = 32;

    // Configuration register indexes.
    localparam logic [1:0] REG_KEY_WORD_0 = 2'd0;
    localparam logic [1:0] REG_KEY_WORD_1 = 2'd1;
    localparam logic [1:0] REG_KEY_WORD_2 = 2'd2;
    localparam logic [1:0] REG_KEY_WORD_3 = 2'd3;

    // Command codes.
    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    typedef logic [KEY_WORDS-1:0][WORD_W-1:0] xtea_key_t;

    typedef struct packed {
        logic              command;
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
    } xtea_word_t;

    // Running sum after n rounds, modulo 2^32. Only used on constants.
    function automatic logic [31:0] xtea_sum(input int unsigned n);
        logic [63:0] prod;
        prod = 64'(n) * 64'(DELTA);
        return prod[31:0];
    endfunction

    function automatic logic [31:0] xtea_mix(input logic [31:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/xtea_if.sv
`default_nettype none

interface xtea_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [31:0] half_first_in;
    logic [31:0] half_second_in;

    modport source (output valid, output command, output half_first_in,
                    output half_second_in, input ready);
    modport sink   (input valid, input command, input half_first_in,
                    input half_second_in, output ready);
endinterface

interface xtea_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] half_first_out;
    logic [31:0] half_second_out;

    modport source (output valid, output half_first_out, output half_second_out,
                    input ready);
    modport sink   (input valid, input half_first_out, input half_second_out,
                    output ready);
endinterface

`default_nettype wire

>>> hw/rtl/xtea_cell.sv
`default_nettype none

module xtea_cell #(
    parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT,
    parameter int STAGE       = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                up_valid,
    output logic                up_ready,
    input  xtea_pkg::xtea_word_t up_data,
    input  xtea_pkg::xtea_key_t  key,
    output logic                down_valid,
    input  logic                down_ready,
    output xtea_pkg::xtea_word_t down_data
);
    import xtea_pkg::*;

    // Each cell does one half-round; two cells make one full round.
    localparam int ROUND = STAGE / 2;
    localparam int HALF  = STAGE % 2;
    localparam logic HALF_ONE = (HALF == 1);

    localparam logic [31:0] ENC_SUM = xtea_sum(ROUND + HALF);
    localparam logic [31:0] DEC_SUM = xtea_sum(ROUND_COUNT - ROUND - HALF);
    localparam logic [1:0] ENC_KEY_IDX = (HALF == 0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [1:0] DEC_KEY_IDX = (HALF == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

    logic        valid_reg;
    logic        valid_next;
    xtea_word_t  data_reg;
    xtea_word_t  data_next;
    logic        upd_first;
    logic        is_dec;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] round_key;
    logic [31:0] round_sum;
    logic [31:0] tweak;
    logic [31:0] dst_new;

    // Encryption updates the first half in the even cell, decryption in the odd one.
    assign is_dec    = (up_data.command == CMD_DECRYPT);
    assign upd_first = (up_data.command == HALF_ONE);

    always_comb
    begin
        src       = upd_first ? up_data.v1 : up_data.v0;
        dst       = upd_first ? up_data.v0 : up_data.v1;
        round_key = is_dec ? key[DEC_KEY_IDX] : key[ENC_KEY_IDX];
        round_sum = is_dec ? DEC_SUM : ENC_SUM;
        tweak     = xtea_mix(src) ^ (round_sum + round_key);
        dst_new   = is_dec ? (dst - tweak) : (dst + tweak);

        data_next.command = up_data.command;
        data_next.v0      = upd_first ? dst_new : up_data.v0;
        data_next.v1      = upd_first ? up_data.v1 : dst_new;
    end

    assign up_ready   = !valid_reg || down_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/xtea_block_cipher.sv
`default_nettype none

// Channel  Dir  Fields                                   Accepted when
// req      in   command, half_first_in, half_second_in   req.valid && req.ready
// rsp      out  half_first_out, half_second_out          rsp.valid && rsp.ready
// cfg      in   cfg_index, cfg_data                      cfg_we
//
// One item enters per cycle while req.ready is high; each item passes through every
// cell of the chain after it is accepted, one half-round per cell of the chain.
// Every cell holds its own item and can fill while cells further down are stalled,
// so ready upstream stays high as long as any cell ahead of the stall is empty.
// Reset clears all valid flags and sets the four key words to zero.

module xtea_block_cipher #(
    parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    xtea_req_if.sink          req,
    xtea_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import xtea_pkg::*;

    localparam int STAGE_COUNT = 2 * ROUND_COUNT;

    xtea_key_t  key_reg;
    xtea_key_t  key_next;
    logic       stage_valid [STAGE_COUNT+1];
    logic       stage_ready [STAGE_COUNT+1];
    xtea_word_t stage_data  [STAGE_COUNT+1];

    always_comb
    begin
        key_next = key_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_next[0] = cfg_data;
                REG_KEY_WORD_1: key_next[1] = cfg_data;
                REG_KEY_WORD_2: key_next[2] = cfg_data;
                REG_KEY_WORD_3: key_next[3] = cfg_data;
                default:        key_next    = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign stage_valid[0]        = req.valid;
    assign req.ready             = stage_ready[0];
    assign stage_data[0].command = req.command;
    assign stage_data[0].v0      = req.half_first_in;
    assign stage_data[0].v1      = req.half_second_in;

    for (genvar i = 0; i < STAGE_COUNT; i++)
    begin : g_cell
        xtea_cell #(
            .ROUND_COUNT (ROUND_COUNT),
            .STAGE       (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stage_valid[i]),
            .up_ready   (stage_ready[i]),
            .up_data    (stage_data[i]),
            .key        (key_reg),
            .down_valid (stage_valid[i+1]),
            .down_ready (stage_ready[i+1]),
            .down_data  (stage_data[i+1])
        );
    end

    assign rsp.valid                = stage_valid[STAGE_COUNT];
    assign stage_ready[STAGE_COUNT] = rsp.ready;
    assign rsp.half_first_out       = stage_data[STAGE_COUNT].v0;
    assign rsp.half_second_out      = stage_data[STAGE_COUNT].v1;

endmodule

`default_nettype wire

>>> hw/rtl/xtea_checker.sv
`default_nettype none

module xtea_checker #(
    parameter int ROUND_COUNT = xtea_pkg::ROUND_COUNT_DEFAULT
) (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready
);
    localparam int STAGE_COUNT = 2 * ROUND_COUNT;
    localparam int CNT_W = $clog2(STAGE_COUNT + 2);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Items inside the chain: accepted but not yet delivered.
    assign count_next = count_reg + CNT_W'(req_valid && req_ready)
                      - CNT_W'(rsp_valid && rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result item dropped while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || rsp_ready) |-> req_ready)
        else $error("input stalled while the output side can move");

    a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> !rsp_valid)
        else $error("result item with no item in flight");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STAGE_COUNT))
        else $error("more items in flight than cells");

endmodule

bind xtea_block_cipher xtea_checker #(
    .ROUND_COUNT (ROUND_COUNT)
) u_xtea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);

`default_nettype wire
